>>> design/radix_integer_text_parser_defines.svh
// ----------------------------------------------------------------------------
// radix integer text parser assertion macros
// shared assertion forms used by the parser's rtl
// ----------------------------------------------------------------------------
`ifndef RADIX_INTEGER_TEXT_PARSER_DEFINES_SVH
`define RADIX_INTEGER_TEXT_PARSER_DEFINES_SVH

// same-cycle implication, checked out of reset
`define RIT_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("parser check failed");

// next-cycle implication, checked out of reset
`define RIT_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("parser check failed");

`endif

>>> design/rit_pkg.sv
// ----------------------------------------------------------------------------
// rit_pkg
// types, character codes and helper functions of the integer text parser
// ----------------------------------------------------------------------------
package rit_pkg;

    localparam int OFFSET_W = 16;
    localparam int RADIX_W  = 5;
    localparam int ACC_W    = 32;

    localparam logic [7:0] CH_ZERO     = 8'h30;  // '0'
    localparam logic [7:0] CH_NINE     = 8'h39;  // '9'
    localparam logic [7:0] CH_X        = 8'h78;  // 'x'
    localparam logic [7:0] CH_PLUS     = 8'h2b;  // '+'
    localparam logic [7:0] CH_MINUS    = 8'h2d;  // '-'
    localparam logic [7:0] CH_SPACE    = 8'h20;
    localparam logic [7:0] CH_TAB      = 8'h09;
    localparam logic [7:0] CH_CR       = 8'h0d;
    localparam logic [7:0] CH_LC_A     = 8'h61;
    localparam logic [7:0] CH_LC_F     = 8'h66;
    localparam logic [7:0] CH_UC_A     = 8'h41;
    localparam logic [7:0] CH_UC_F     = 8'h46;
    localparam logic [7:0] LC_BIAS     = 8'h57;  // 'a' - 10
    localparam logic [7:0] UC_BIAS     = 8'h37;  // 'A' - 10

    localparam logic [RADIX_W-1:0] RADIX_BIN     = 5'd2;
    localparam logic [RADIX_W-1:0] RADIX_OCT     = 5'd8;
    localparam logic [RADIX_W-1:0] RADIX_DEFAULT = 5'd10;
    localparam logic [RADIX_W-1:0] RADIX_HEX     = 5'd16;

    localparam logic [OFFSET_W-1:0] PREFIX_LEN = OFFSET_W'(2);

    typedef enum logic [2:0] {
        PH_IDLE,
        PH_ZERO,
        PH_SPACE,
        PH_PLUS,
        PH_DIGITS,
        PH_DONE
    } rit_phase_t;

    typedef struct packed {
        logic [7:0] ch;
        logic       first;
    } rit_in_t;

    typedef struct packed {
        logic signed [ACC_W-1:0] value;
        logic [OFFSET_W-1:0]     end_offset;
    } rit_out_t;

    typedef struct packed {
        rit_phase_t           phase;
        logic [ACC_W-1:0]     acc;
        logic                 neg;
        logic [RADIX_W-1:0]   radix;
        logic [OFFSET_W-1:0]  offset;
    } rit_state_t;

    // radix values that take digits at all
    function automatic logic radix_ok(input logic [RADIX_W-1:0] r);
        return (r == RADIX_BIN) || (r == RADIX_OCT) || (r == RADIX_DEFAULT) || (r == RADIX_HEX);
    endfunction

    // digit decode: valid flag over a four-bit digit value
    function automatic logic [4:0] digit_of(input logic [7:0] c);
        logic [7:0] d;
        logic       v;
        d = 8'h00;
        v = 1'b0;
        if (c >= CH_ZERO && c <= CH_NINE) begin
            d = c - CH_ZERO;
            v = 1'b1;
        end else if (c >= CH_LC_A && c <= CH_LC_F) begin
            d = c - LC_BIAS;
            v = 1'b1;
        end else if (c >= CH_UC_A && c <= CH_UC_F) begin
            d = c - UC_BIAS;
            v = 1'b1;
        end
        return {v, d[3:0]};
    endfunction

    // accumulator times radix, as shifts and at most one add
    function automatic logic [ACC_W-1:0] mul_radix(input logic [ACC_W-1:0] a,
                                                   input logic [RADIX_W-1:0] r);
        logic [ACC_W-1:0] p;
        case (r)
            RADIX_BIN:     p = a << 1;
            RADIX_OCT:     p = a << 3;
            RADIX_DEFAULT: p = (a << 3) + (a << 1);
            RADIX_HEX:     p = a << 4;
            default:       p = a;
        endcase
        return p;
    endfunction

endpackage

>>> design/rit_step.sv
// ----------------------------------------------------------------------------
// rit_step
// one character of parse: next parser state and the result it may cause
// ----------------------------------------------------------------------------
module rit_step (
    input  rit_pkg::rit_state_t                st,
    input  rit_pkg::rit_in_t                   item,
    input  logic [rit_pkg::RADIX_W-1:0]        cfg_radix,
    output rit_pkg::rit_state_t                st_next,
    output logic                               emit,
    output rit_pkg::rit_out_t                  result
);
    import rit_pkg::*;

    logic [RADIX_W-1:0]  cfg_eff;
    logic                in_zero;
    logic                hold_zero;
    logic                take_x;
    logic                zero_fail;
    logic                run;
    rit_phase_t          b_phase;
    logic [ACC_W-1:0]    b_acc;
    logic                b_neg;
    logic [RADIX_W-1:0]  b_radix;
    logic [OFFSET_W-1:0] b_off;
    logic [OFFSET_W-1:0] off_inc;
    logic [4:0]          dig;
    logic                p_active;
    logic                p_space;
    logic                p_plus;
    logic                p_minus;
    logic                p_digit;
    logic                p_consume;
    logic                p_finish;
    logic                is_space;

    // radix zero selects decimal
    assign cfg_eff = (cfg_radix == '0) ? RADIX_DEFAULT : cfg_radix;

    // leading zero handling around the hex prefix
    assign in_zero   = !item.first && (st.phase == PH_ZERO);
    assign hold_zero = item.first && (item.ch == CH_ZERO);
    assign take_x    = in_zero && (item.ch == CH_X);
    assign zero_fail = in_zero && (item.ch != CH_X) && !radix_ok(st.radix);
    assign run       = !hold_zero && !take_x && !zero_fail;

    // state the character is parsed against
    always_comb
    begin
        if (item.first) begin
            b_phase = PH_SPACE;
            b_acc   = '0;
            b_neg   = 1'b0;
            b_radix = cfg_eff;
            b_off   = '0;
        end else if (in_zero) begin
            // held zero already taken as a digit
            b_phase = PH_DIGITS;
            b_acc   = '0;
            b_neg   = 1'b0;
            b_radix = st.radix;
            b_off   = OFFSET_W'(1);
        end else begin
            b_phase = st.phase;
            b_acc   = st.acc;
            b_neg   = st.neg;
            b_radix = st.radix;
            b_off   = st.offset;
        end
    end

    // character classes
    always_comb
    begin
        case (item.ch) inside
            [CH_TAB:CH_CR], CH_SPACE: is_space = 1'b1;
            default:                  is_space = 1'b0;
        endcase
    end

    assign dig       = digit_of(item.ch);
    assign p_active  = (b_phase == PH_SPACE) || (b_phase == PH_PLUS) || (b_phase == PH_DIGITS);
    assign p_space   = (b_phase == PH_SPACE) && is_space;
    assign p_plus    = (b_phase == PH_SPACE) && (item.ch == CH_PLUS);
    assign p_minus   = ((b_phase == PH_SPACE) || (b_phase == PH_PLUS)) && (item.ch == CH_MINUS);
    assign p_digit   = p_active && dig[4] && radix_ok(b_radix) && ({1'b0, dig[3:0]} < b_radix);
    assign p_consume = p_space || p_plus || p_minus || p_digit;
    assign p_finish  = p_active && !p_consume;
    assign off_inc   = (b_off == '1) ? b_off : b_off + OFFSET_W'(1);

    // next state
    always_comb
    begin
        st_next = st;
        if (hold_zero) begin
            st_next.phase  = PH_ZERO;
            st_next.acc    = '0;
            st_next.neg    = 1'b0;
            st_next.radix  = cfg_eff;
            st_next.offset = '0;
        end else if (take_x) begin
            st_next.phase  = PH_SPACE;
            st_next.radix  = RADIX_HEX;
            st_next.offset = PREFIX_LEN;
        end else if (zero_fail) begin
            st_next.phase  = PH_DONE;
        end else begin
            st_next.phase  = b_phase;
            st_next.acc    = b_acc;
            st_next.neg    = b_neg;
            st_next.radix  = b_radix;
            st_next.offset = b_off;
            if (p_plus) begin
                st_next.phase = PH_PLUS;
            end
            if (p_minus) begin
                st_next.neg   = 1'b1;
                st_next.phase = PH_DIGITS;
            end
            if (p_digit) begin
                st_next.acc   = mul_radix(b_acc, b_radix) + ACC_W'(dig[3:0]);
                st_next.phase = PH_DIGITS;
            end
            if (p_consume) begin
                st_next.offset = off_inc;
            end
            if (p_finish) begin
                st_next.phase = PH_DONE;
            end
        end
    end

    // result of a finished parse
    always_comb
    begin
        emit = zero_fail || (run && p_finish);
        if (zero_fail) begin
            result.value      = '0;
            result.end_offset = '0;
        end else begin
            result.value      = $signed(b_neg ? (ACC_W'(0) - b_acc) : b_acc);
            result.end_offset = b_off;
        end
    end

endmodule

>>> design/rit_out_stage.sv
// ----------------------------------------------------------------------------
// rit_out_stage
// result register between the parse logic and the output channel
// ----------------------------------------------------------------------------
module rit_out_stage (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              load,
    input  rit_pkg::rit_out_t load_data,
    output logic              can_take,
    output logic              out_valid,
    input  logic              out_ready,
    output rit_pkg::rit_out_t out_data
);
    import rit_pkg::*;

    logic     valid_reg;
    logic     valid_next;
    rit_out_t data_reg;

    // upstream may move whenever this register is free or draining
    assign can_take = !valid_reg || out_ready;

    // valid tracking
    always_comb
    begin
        if (load) begin
            valid_next = 1'b1;
        end else if (out_ready) begin
            valid_next = 1'b0;
        end else begin
            valid_next = valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    // result beat payload
    always_ff @(posedge clk)
    begin
        if (load) begin
            data_reg <= load_data;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

>>> design/radix_integer_text_parser.sv
// ----------------------------------------------------------------------------
// radix_integer_text_parser
// streaming ascii integer parser, one character per beat
// ----------------------------------------------------------------------------
// Takes one character per cycle, every cycle, while the result register is
// free or being drained; a result appears on the output in the cycle after the
// character that ends the parse. The rate is set by the single output
// register: in_ready is low only while a result waits and out_ready is low.
// The radix register is sampled at each first character; write it while the
// block is idle.
`include "radix_integer_text_parser_defines.svh"

module radix_integer_text_parser (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_valid,
    output logic                        cfg_ready,
    input  logic [rit_pkg::RADIX_W-1:0] cfg_data,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  rit_pkg::rit_in_t            in_data,
    output logic                        out_valid,
    input  logic                        out_ready,
    output rit_pkg::rit_out_t           out_data
);
    import rit_pkg::*;

    logic [RADIX_W-1:0] radix_reg;
    rit_state_t         state_reg;
    rit_state_t         state_next;
    logic               step_emit;
    rit_out_t           step_result;
    logic               in_take;

    // radix register, always writable
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            radix_reg <= RADIX_DEFAULT;
        end else if (cfg_valid) begin
            radix_reg <= cfg_data;
        end
    end

    // parse logic
    rit_step u_step (
        .st        (state_reg),
        .item      (in_data),
        .cfg_radix (radix_reg),
        .st_next   (state_next),
        .emit      (step_emit),
        .result    (step_result)
    );

    assign in_take = in_valid && in_ready;

    // parser state advances on each accepted beat
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg.phase  <= PH_IDLE;
            state_reg.acc    <= '0;
            state_reg.neg    <= 1'b0;
            state_reg.radix  <= RADIX_DEFAULT;
            state_reg.offset <= '0;
        end else if (in_take) begin
            state_reg <= state_next;
        end
    end

    // result register
    rit_out_stage u_out (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (in_take && step_emit),
        .load_data (step_result),
        .can_take  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

    // a first character always opens a string
    `RIT_ASSERT_NEXT(a_first_opens, clk, rst_n, in_take && in_data.first,
        state_reg.phase != PH_IDLE && state_reg.phase != PH_DONE || $past(step_emit))

    // a result always closes the string
    `RIT_ASSERT_NEXT(a_emit_closes, clk, rst_n, in_take && step_emit,
        state_reg.phase == PH_DONE && out_valid)

    // characters outside a string give no result
    `RIT_ASSERT_SAME(a_idle_silent, clk, rst_n,
        !in_data.first && (state_reg.phase == PH_IDLE || state_reg.phase == PH_DONE),
        !step_emit)

endmodule
